### rtl/i2c_master_transaction_sequencer_defines.svh
// Assertion macros shared by the I2C transaction sequencer RTL.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

### rtl/i2cs_pkg.sv
// Types, codes and sizes for the I2C master transaction sequencer.
package i2cs_pkg;

    localparam int WRITE_DEPTH = 16;
    localparam int READ_DEPTH  = 16;

    // Counters must hold the depth itself.
    localparam int WCNT_W = $clog2(WRITE_DEPTH + 1);
    localparam int RCNT_W = $clog2(READ_DEPTH + 1);
    localparam int WIDX_W = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

    typedef logic [2:0] t_kind;
    typedef logic [2:0] t_cmd;
    typedef logic [2:0] t_outcome;

    localparam t_kind KIND_START    = 3'd0;
    localparam t_kind KIND_LOAD     = 3'd1;
    localparam t_kind KIND_WR_DONE  = 3'd2;
    localparam t_kind KIND_RX_BYTE  = 3'd3;
    localparam t_kind KIND_ARB_LOST = 3'd4;
    localparam t_kind KIND_BUS_ERR  = 3'd5;
    localparam t_kind KIND_UNEXP    = 3'd6;

    localparam t_cmd CMD_NONE       = 3'd0;
    localparam t_cmd CMD_ADDR_WRITE = 3'd1;
    localparam t_cmd CMD_ADDR_READ  = 3'd2;
    localparam t_cmd CMD_SEND_DATA  = 3'd3;
    localparam t_cmd CMD_ACK_NEXT   = 3'd4;
    localparam t_cmd CMD_STOP       = 3'd5;
    localparam t_cmd CMD_NACK_STOP  = 3'd6;

    localparam t_outcome OUT_UNKNOWN  = 3'd0;
    localparam t_outcome OUT_OK       = 3'd1;
    localparam t_outcome OUT_OVERFLOW = 3'd2;
    localparam t_outcome OUT_ARBLOST  = 3'd3;
    localparam t_outcome OUT_BUSERR   = 3'd4;
    localparam t_outcome OUT_NACK     = 3'd5;
    localparam t_outcome OUT_FAIL     = 3'd6;

    localparam logic [7:0] DIR_READ = 8'h01;

endpackage

### rtl/i2c_master_transaction_sequencer.sv
// Top level of the I2C master write-then-read transaction sequencer.
// Every input beat (start request, write-buffer load or bus event) produces
// exactly one result beat carrying the bus command, any delivered read byte,
// the idle flag and the outcome code. The block takes one beat per clock
// while the sink keeps up: the sequencing state, the write buffer and the
// output register all update at the edge where a beat is taken.
// The input side stays ready while the output register is empty or is being
// emptied in the same cycle, so with a ready sink the rate is one beat per
// cycle. The write buffer powers up with unknown contents; sending a byte
// that was never loaded gives an undefined value.
`include "i2c_master_transaction_sequencer_defines.svh"

module i2c_master_transaction_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_kind,
    input  logic [6:0] i_slave_address,
    input  logic [7:0] i_write_count,
    input  logic [7:0] i_read_count,
    input  logic [3:0] i_byte_index,
    input  logic [7:0] i_data_byte,
    input  logic       i_slave_nack,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_accepted,
    output logic [2:0] o_bus_command,
    output logic [7:0] o_bus_byte,
    output logic       o_read_valid,
    output logic [3:0] o_read_position,
    output logic [7:0] o_read_value,
    output logic       o_idle,
    output logic [2:0] o_outcome
);

    // Sequencing state.
    logic                          r_ready, n_ready;
    i2cs_pkg::t_outcome            r_outcome, n_outcome;
    logic [7:0]                    r_addr, n_addr;
    logic [i2cs_pkg::WCNT_W-1:0]   r_to_write, n_to_write;
    logic [i2cs_pkg::RCNT_W-1:0]   r_to_read, n_to_read;
    logic [i2cs_pkg::WCNT_W-1:0]   r_written, n_written;
    logic [i2cs_pkg::RCNT_W-1:0]   r_read, n_read;
    logic [7:0]                    r_store [i2cs_pkg::WRITE_DEPTH];

    // Result register.
    logic                 r_out_valid;
    logic                 r_accepted, n_accepted;
    i2cs_pkg::t_cmd       r_cmd, n_cmd;
    logic [7:0]           r_bus_byte, n_bus_byte;
    logic                 r_rvalid, n_rvalid;
    logic [3:0]           r_rpos, n_rpos;
    logic [7:0]           r_rval, n_rval;

    logic                          in_accept;
    logic                          store_we;
    logic [i2cs_pkg::RCNT_W-1:0]   read_inc;
    logic [7:0]                    store_rd;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign read_inc   = r_read + 1'b1;
    // The index is below to_write whenever a byte is sent, and to_write never exceeds the depth.
    assign store_rd   = r_store[r_written[i2cs_pkg::WIDX_W-1:0]];

    always_comb begin
        n_ready    = r_ready;
        n_outcome  = r_outcome;
        n_addr     = r_addr;
        n_to_write = r_to_write;
        n_to_read  = r_to_read;
        n_written  = r_written;
        n_read     = r_read;
        n_accepted = 1'b0;
        n_cmd      = i2cs_pkg::CMD_NONE;
        n_bus_byte = 8'h00;
        n_rvalid   = 1'b0;
        n_rpos     = 4'h0;
        n_rval     = 8'h00;
        store_we   = 1'b0;
        case (i_kind)
            i2cs_pkg::KIND_START: begin
                if (r_ready && (int'(i_write_count) <= i2cs_pkg::WRITE_DEPTH)
                        && (int'(i_read_count) <= i2cs_pkg::READ_DEPTH)) begin
                    n_accepted = 1'b1;
                    n_addr     = {i_slave_address, 1'b0};
                    n_to_write = i2cs_pkg::WCNT_W'(i_write_count);
                    n_to_read  = i2cs_pkg::RCNT_W'(i_read_count);
                    n_written  = '0;
                    n_read     = '0;
                    n_outcome  = i2cs_pkg::OUT_UNKNOWN;
                    if (i_write_count != 8'h00) begin
                        n_ready    = 1'b0;
                        n_cmd      = i2cs_pkg::CMD_ADDR_WRITE;
                        n_bus_byte = {i_slave_address, 1'b0};
                    end else if (i_read_count != 8'h00) begin
                        n_ready    = 1'b0;
                        n_cmd      = i2cs_pkg::CMD_ADDR_READ;
                        n_bus_byte = {i_slave_address, 1'b0} | i2cs_pkg::DIR_READ;
                    end else begin
                        // Nothing to move: the transaction completes at once.
                        n_outcome = i2cs_pkg::OUT_OK;
                    end
                end
            end
            i2cs_pkg::KIND_LOAD: begin
                store_we = int'(i_byte_index) < i2cs_pkg::WRITE_DEPTH;
            end
            i2cs_pkg::KIND_WR_DONE: begin
                if (!r_ready) begin
                    if (i_slave_nack) begin
                        n_cmd     = i2cs_pkg::CMD_STOP;
                        n_outcome = i2cs_pkg::OUT_NACK;
                        n_ready   = 1'b1;
                    end else if (r_written < r_to_write) begin
                        n_cmd      = i2cs_pkg::CMD_SEND_DATA;
                        n_bus_byte = store_rd;
                        n_written  = r_written + 1'b1;
                    end else if (r_read < r_to_read) begin
                        n_cmd      = i2cs_pkg::CMD_ADDR_READ;
                        n_bus_byte = r_addr | i2cs_pkg::DIR_READ;
                    end else begin
                        n_cmd     = i2cs_pkg::CMD_STOP;
                        n_outcome = i2cs_pkg::OUT_OK;
                        n_ready   = 1'b1;
                    end
                end
            end
            i2cs_pkg::KIND_RX_BYTE: begin
                if (!r_ready) begin
                    if (int'(r_read) >= i2cs_pkg::READ_DEPTH) begin
                        n_cmd     = i2cs_pkg::CMD_STOP;
                        n_outcome = i2cs_pkg::OUT_OVERFLOW;
                        n_ready   = 1'b1;
                    end else begin
                        // A byte beyond the requested count is still delivered.
                        n_rvalid = 1'b1;
                        n_rpos   = 4'(r_read);
                        n_rval   = i_data_byte;
                        n_read   = read_inc;
                        if (read_inc < r_to_read) begin
                            n_cmd = i2cs_pkg::CMD_ACK_NEXT;
                        end else begin
                            n_cmd     = i2cs_pkg::CMD_NACK_STOP;
                            n_outcome = i2cs_pkg::OUT_OK;
                            n_ready   = 1'b1;
                        end
                    end
                end
            end
            i2cs_pkg::KIND_ARB_LOST: begin
                n_outcome = i2cs_pkg::OUT_ARBLOST;
                n_ready   = 1'b1;
            end
            i2cs_pkg::KIND_BUS_ERR: begin
                n_outcome = i2cs_pkg::OUT_BUSERR;
                n_ready   = 1'b1;
            end
            i2cs_pkg::KIND_UNEXP: begin
                n_outcome = i2cs_pkg::OUT_FAIL;
                n_ready   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b1;
            r_outcome   <= i2cs_pkg::OUT_UNKNOWN;
            r_addr      <= 8'h00;
            r_to_write  <= '0;
            r_to_read   <= '0;
            r_written   <= '0;
            r_read      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_ready    <= n_ready;
                r_outcome  <= n_outcome;
                r_addr     <= n_addr;
                r_to_write <= n_to_write;
                r_to_read  <= n_to_read;
                r_written  <= n_written;
                r_read     <= n_read;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the idle flag and outcome come from the updated state.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_accepted <= n_accepted;
            r_cmd      <= n_cmd;
            r_bus_byte <= n_bus_byte;
            r_rvalid   <= n_rvalid;
            r_rpos     <= n_rpos;
            r_rval     <= n_rval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && store_we) begin
            r_store[i2cs_pkg::WIDX_W'(i_byte_index)] <= i_data_byte;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_accepted;
    assign o_bus_command   = r_cmd;
    assign o_bus_byte      = r_bus_byte;
    assign o_read_valid    = r_rvalid;
    assign o_read_position = r_rpos;
    assign o_read_value    = r_rval;
    assign o_idle          = r_ready;
    assign o_outcome       = r_outcome;

    `I2CS_ASSERT_NOW(a_read_answer, i_clk, i_rst_n, o_out_valid && o_read_valid,
        o_bus_command == i2cs_pkg::CMD_ACK_NEXT || o_bus_command == i2cs_pkg::CMD_NACK_STOP)
    `I2CS_ASSERT_NOW(a_addr_busy, i_clk, i_rst_n,
        o_out_valid && (o_bus_command == i2cs_pkg::CMD_ADDR_WRITE
            || o_bus_command == i2cs_pkg::CMD_SEND_DATA
            || o_bus_command == i2cs_pkg::CMD_ACK_NEXT),
        !o_idle)
    `I2CS_ASSERT_NOW(a_write_bound, i_clk, i_rst_n, 1'b1, r_written <= r_to_write)
    `I2CS_ASSERT_NEXT(a_stop_idle, i_clk, i_rst_n,
        in_accept && (n_cmd == i2cs_pkg::CMD_STOP || n_cmd == i2cs_pkg::CMD_NACK_STOP),
        o_idle && o_out_valid)

endmodule

### sim/i2c_master_transaction_sequencer_tb.sv
// Self-checking testbench for the I2C master transaction sequencer.
module i2c_master_transaction_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam i2cs_pkg::t_kind KIND_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_BEATS   = 1800;
    localparam int MAX_WAIT       = 12;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        i2cs_pkg::t_kind kind;
        logic [6:0]      slave_address;
        logic [7:0]      write_count;
        logic [7:0]      read_count;
        logic [3:0]      byte_index;
        logic [7:0]      data_byte;
        logic            slave_nack;
    } beat_t;

    typedef struct packed {
        logic               accepted;
        i2cs_pkg::t_cmd     bus_command;
        logic [7:0]         bus_byte;
        logic               read_valid;
        logic [3:0]         read_position;
        logic [7:0]         read_value;
        logic               idle;
        i2cs_pkg::t_outcome outcome;
    } result_t;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic [2:0] i_kind          = '0;
    logic [6:0] i_slave_address = '0;
    logic [7:0] i_write_count   = '0;
    logic [7:0] i_read_count    = '0;
    logic [3:0] i_byte_index    = '0;
    logic [7:0] i_data_byte     = '0;
    logic       i_slave_nack    = 1'b0;
    logic       i_out_ready     = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_accepted;
    logic [2:0] o_bus_command;
    logic [7:0] o_bus_byte;
    logic       o_read_valid;
    logic [3:0] o_read_position;
    logic [7:0] o_read_value;
    logic       o_idle;
    logic [2:0] o_outcome;

    i2c_master_transaction_sequencer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_slave_address (i_slave_address),
        .i_write_count   (i_write_count),
        .i_read_count    (i_read_count),
        .i_byte_index    (i_byte_index),
        .i_data_byte     (i_data_byte),
        .i_slave_nack    (i_slave_nack),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_bus_command   (o_bus_command),
        .o_bus_byte      (o_bus_byte),
        .o_read_valid    (o_read_valid),
        .o_read_position (o_read_position),
        .o_read_value    (o_read_value),
        .o_idle          (o_idle),
        .o_outcome       (o_outcome)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Mirror of the sequencer state.
    logic               seq_ready;
    i2cs_pkg::t_outcome seq_outcome;
    logic [7:0]         seq_address;
    int                 seq_to_write;
    int                 seq_to_read;
    int                 seq_written;
    int                 seq_read;
    logic [7:0]         seq_store [i2cs_pkg::WRITE_DEPTH];

    beat_t   pending_beats [$];
    result_t expected_results [$];
    logic [i2cs_pkg::WRITE_DEPTH-1:0] loaded_entries = '0;

    int  error_count = 0;
    int  cycle_count = 0;
    bit  in_taken    = 1'b0;
    bit  out_taken   = 1'b0;
    bit  in_burst    = 1'b0;
    bit  out_burst   = 1'b0;
    int  in_gap      = 0;
    int  out_stall   = 0;
    beat_t   next_beat;
    beat_t   seen_beat;
    result_t fresh_result;
    result_t oldest_result;

    task automatic reset_sequencer_mirror();
        seq_ready    = 1'b1;
        seq_outcome  = i2cs_pkg::OUT_UNKNOWN;
        seq_address  = '0;
        seq_to_write = 0;
        seq_to_read  = 0;
        seq_written  = 0;
        seq_read     = 0;
        for (int i = 0; i < i2cs_pkg::WRITE_DEPTH; i++) seq_store[i] = '0;
    endtask

    task automatic predict_sequencer(input beat_t b, output result_t r);
        r = '0;
        r.bus_command = i2cs_pkg::CMD_NONE;
        case (b.kind)
            i2cs_pkg::KIND_START: begin
                if (seq_ready && b.write_count <= i2cs_pkg::WRITE_DEPTH
                        && b.read_count <= i2cs_pkg::READ_DEPTH) begin
                    r.accepted   = 1'b1;
                    seq_address  = {b.slave_address, 1'b0};
                    seq_to_write = int'(b.write_count);
                    seq_to_read  = int'(b.read_count);
                    seq_written  = 0;
                    seq_read     = 0;
                    seq_outcome  = i2cs_pkg::OUT_UNKNOWN;
                    if (seq_to_write > 0) begin
                        seq_ready     = 1'b0;
                        r.bus_command = i2cs_pkg::CMD_ADDR_WRITE;
                        r.bus_byte    = seq_address;
                    end else if (seq_to_read > 0) begin
                        seq_ready     = 1'b0;
                        r.bus_command = i2cs_pkg::CMD_ADDR_READ;
                        r.bus_byte    = seq_address | i2cs_pkg::DIR_READ;
                    end else begin
                        seq_outcome = i2cs_pkg::OUT_OK;
                    end
                end
            end
            i2cs_pkg::KIND_LOAD: begin
                if (b.byte_index < i2cs_pkg::WRITE_DEPTH) seq_store[b.byte_index] = b.data_byte;
            end
            i2cs_pkg::KIND_WR_DONE: begin
                if (!seq_ready) begin
                    if (b.slave_nack) begin
                        r.bus_command = i2cs_pkg::CMD_STOP;
                        seq_outcome   = i2cs_pkg::OUT_NACK;
                        seq_ready     = 1'b1;
                    end else if (seq_written < seq_to_write) begin
                        r.bus_command = i2cs_pkg::CMD_SEND_DATA;
                        r.bus_byte    = (seq_written < i2cs_pkg::WRITE_DEPTH)
                                        ? seq_store[seq_written] : 8'h00;
                        seq_written++;
                    end else if (seq_read < seq_to_read) begin
                        r.bus_command = i2cs_pkg::CMD_ADDR_READ;
                        r.bus_byte    = seq_address | i2cs_pkg::DIR_READ;
                    end else begin
                        r.bus_command = i2cs_pkg::CMD_STOP;
                        seq_outcome   = i2cs_pkg::OUT_OK;
                        seq_ready     = 1'b1;
                    end
                end
            end
            i2cs_pkg::KIND_RX_BYTE: begin
                if (!seq_ready) begin
                    if (seq_read >= i2cs_pkg::READ_DEPTH) begin
                        r.bus_command = i2cs_pkg::CMD_STOP;
                        seq_outcome   = i2cs_pkg::OUT_OVERFLOW;
                        seq_ready     = 1'b1;
                    end else begin
                        r.read_valid    = 1'b1;
                        r.read_position = 4'(seq_read);
                        r.read_value    = b.data_byte;
                        seq_read++;
                        if (seq_read < seq_to_read) begin
                            r.bus_command = i2cs_pkg::CMD_ACK_NEXT;
                        end else begin
                            r.bus_command = i2cs_pkg::CMD_NACK_STOP;
                            seq_outcome   = i2cs_pkg::OUT_OK;
                            seq_ready     = 1'b1;
                        end
                    end
                end
            end
            i2cs_pkg::KIND_ARB_LOST: begin
                seq_outcome = i2cs_pkg::OUT_ARBLOST;
                seq_ready   = 1'b1;
            end
            i2cs_pkg::KIND_BUS_ERR: begin
                seq_outcome = i2cs_pkg::OUT_BUSERR;
                seq_ready   = 1'b1;
            end
            i2cs_pkg::KIND_UNEXP: begin
                seq_outcome = i2cs_pkg::OUT_FAIL;
                seq_ready   = 1'b1;
            end
            default: begin
            end
        endcase
        r.idle    = seq_ready;
        r.outcome = seq_outcome;
    endtask

    function automatic beat_t random_beat(input i2cs_pkg::t_kind k);
        beat_t b;
        b.kind          = k;
        b.slave_address = 7'($urandom);
        b.write_count   = 8'($urandom);
        b.read_count    = 8'($urandom);
        b.byte_index    = 4'($urandom);
        b.data_byte     = 8'($urandom);
        b.slave_nack    = 1'($urandom);
        return b;
    endfunction

    // Any start that could send buffered bytes is preceded by loads of the
    // entries it would read, so no never-written buffer entry is ever sent.
    task automatic push_beat(input beat_t b);
        beat_t fill;
        if (b.kind == i2cs_pkg::KIND_START && b.write_count >= 1
                && b.write_count <= i2cs_pkg::WRITE_DEPTH) begin
            for (int i = 0; i < b.write_count; i++) begin
                if (!loaded_entries[i]) begin
                    fill            = random_beat(i2cs_pkg::KIND_LOAD);
                    fill.byte_index = 4'(i);
                    pending_beats.push_back(fill);
                    loaded_entries[i] = 1'b1;
                end
            end
        end
        if (b.kind == i2cs_pkg::KIND_LOAD) loaded_entries[b.byte_index] = 1'b1;
        pending_beats.push_back(b);
    endtask

    task automatic push_start(input logic [6:0] addr, input int w, input int r);
        beat_t b;
        b               = random_beat(i2cs_pkg::KIND_START);
        b.slave_address = addr;
        b.write_count   = 8'(w);
        b.read_count    = 8'(r);
        push_beat(b);
    endtask

    task automatic push_event(input i2cs_pkg::t_kind k, input logic [7:0] data,
                              input logic nack);
        beat_t b;
        b            = random_beat(k);
        b.data_byte  = data;
        b.slave_nack = nack;
        push_beat(b);
    endtask

    function automatic int pick_count();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return $urandom_range(0, 4);
        if (p < 85) return $urandom_range(5, 15);
        if (p < 93) return 16;
        return $urandom_range(17, 255);
    endfunction

    // A stray beat dropped into a transaction: loads, refused starts,
    // early received bytes, unused kinds and the odd error event.
    task automatic push_interloper();
        int p;
        p = $urandom_range(0, 9);
        if (p < 4)       push_beat(random_beat(i2cs_pkg::KIND_LOAD));
        else if (p < 6)  push_event(i2cs_pkg::KIND_RX_BYTE, 8'($urandom), 1'b0);
        else if (p < 7)  push_beat(random_beat(i2cs_pkg::KIND_START));
        else if (p < 8)  push_beat(random_beat(KIND_UNUSED));
        else             push_beat(random_beat(i2cs_pkg::t_kind'($urandom_range(4, 6))));
    endtask

    task automatic push_transaction();
        int   w;
        int   r;
        logic nack;
        w = pick_count();
        r = pick_count();
        push_start(7'($urandom), w, r);
        if (w > i2cs_pkg::WRITE_DEPTH || r > i2cs_pkg::READ_DEPTH) return;
        if (w > 0) begin
            for (int i = 0; i <= w; i++) begin
                if ($urandom_range(0, 19) == 0) push_interloper();
                nack = ($urandom_range(0, 24) == 0);
                push_event(i2cs_pkg::KIND_WR_DONE, 8'($urandom), nack);
                if (nack) return;
            end
        end
        for (int i = 0; i < r; i++) begin
            if ($urandom_range(0, 29) == 0) push_interloper();
            push_event(i2cs_pkg::KIND_RX_BYTE, 8'($urandom), 1'($urandom));
        end
        if ($urandom_range(0, 9) == 0) push_event(i2cs_pkg::KIND_WR_DONE, 8'($urandom), 1'b0);
    endtask

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Input driver: one beat per handshake, with a random gap before each.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (in_gap > 0) begin
                i_in_valid <= 1'b0;
                in_gap = in_gap - 1;
            end else if (pending_beats.size() > 0) begin
                next_beat = pending_beats.pop_front();
                i_kind          <= next_beat.kind;
                i_slave_address <= next_beat.slave_address;
                i_write_count   <= next_beat.write_count;
                i_read_count    <= next_beat.read_count;
                i_byte_index    <= next_beat.byte_index;
                i_data_byte     <= next_beat.data_byte;
                i_slave_nack    <= next_beat.slave_nack;
                i_in_valid      <= 1'b1;
                if ($urandom_range(0, 99) == 0) in_burst = !in_burst;
                in_gap = draw_wait(in_burst);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result sink: stalls for a random number of cycles before each beat.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                if ($urandom_range(0, 99) == 0) out_burst = !out_burst;
                out_stall = draw_wait(out_burst);
            end
            if (out_stall > 0) begin
                i_out_ready <= 1'b0;
                out_stall = out_stall - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on every accepted input beat, checks every result beat.
    always @(posedge i_clk) begin
        cycle_count++;
        in_taken  = i_rst_n && i_in_valid && o_in_ready;
        out_taken = i_rst_n && o_out_valid && i_out_ready;
        if (in_taken) begin
            seen_beat = '{i_kind, i_slave_address, i_write_count, i_read_count,
                          i_byte_index, i_data_byte, i_slave_nack};
            predict_sequencer(seen_beat, fresh_result);
            expected_results.push_back(fresh_result);
        end
        if (out_taken) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual cmd %0h outcome %0h",
                         $time, o_bus_command, o_outcome);
                error_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                check_field("accepted", 8'(oldest_result.accepted), 8'(o_accepted));
                check_field("bus_command", 8'(oldest_result.bus_command), 8'(o_bus_command));
                check_field("bus_byte", oldest_result.bus_byte, o_bus_byte);
                check_field("read_valid", 8'(oldest_result.read_valid), 8'(o_read_valid));
                check_field("read_position", 8'(oldest_result.read_position),
                            8'(o_read_position));
                check_field("read_value", oldest_result.read_value, o_read_value);
                check_field("idle", 8'(oldest_result.idle), 8'(o_idle));
                check_field("outcome", 8'(oldest_result.outcome), 8'(o_outcome));
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("i2c_master_transaction_sequencer_tb: errors");
        $finish;
    end

    initial begin
        reset_sequencer_mirror();

        // Directed part: idle events, loads at the extremes, every kind of start.
        push_event(i2cs_pkg::KIND_RX_BYTE, 8'hFF, 1'b0);
        push_event(i2cs_pkg::KIND_WR_DONE, 8'h00, 1'b1);
        push_start(7'h7F, 0, 0);
        push_start(7'h12, i2cs_pkg::WRITE_DEPTH + 1, 0);
        push_start(7'h12, 0, 255);
        push_start(7'h7F, 0, 1);
        push_event(i2cs_pkg::KIND_RX_BYTE, 8'hFF, 1'b0);
        push_start(7'h00, 2, 2);
        push_start(7'h55, 1, 1);
        push_event(i2cs_pkg::KIND_WR_DONE, 8'h00, 1'b0);
        push_event(i2cs_pkg::KIND_WR_DONE, 8'h00, 1'b0);
        push_event(i2cs_pkg::KIND_WR_DONE, 8'h00, 1'b0);
        push_event(i2cs_pkg::KIND_RX_BYTE, 8'h00, 1'b0);
        push_event(i2cs_pkg::KIND_RX_BYTE, 8'hA5, 1'b0);
        // A NACK on the address stops the transfer.
        push_start(7'h2A, 1, 0);
        push_event(i2cs_pkg::KIND_WR_DONE, 8'h00, 1'b1);
        // A byte arriving while no read is pending is still delivered.
        push_start(7'h01, 1, 0);
        push_event(i2cs_pkg::KIND_RX_BYTE, 8'h3C, 1'b0);
        push_start(7'h40, i2cs_pkg::WRITE_DEPTH, i2cs_pkg::READ_DEPTH);
        push_event(i2cs_pkg::KIND_ARB_LOST, 8'h00, 1'b0);
        push_event(i2cs_pkg::KIND_BUS_ERR, 8'h00, 1'b0);
        push_event(i2cs_pkg::KIND_UNEXP, 8'h00, 1'b0);
        push_event(KIND_UNUSED, 8'hFF, 1'b1);

        while (pending_beats.size() < RANDOM_BEATS) begin
            if ($urandom_range(0, 99) < 85) push_transaction();
            else push_beat(random_beat(i2cs_pkg::t_kind'($urandom_range(0, 7))));
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_results.size() > 0) error_count++;

        if (error_count == 0) begin
            $display("i2c_master_transaction_sequencer_tb: clean");
        end else begin
            $display("i2c_master_transaction_sequencer_tb: errors");
        end
        $finish;
    end

endmodule

### i2c_master_transaction_sequencer.f
+incdir+rtl
rtl/i2cs_pkg.sv
rtl/i2c_master_transaction_sequencer.sv
sim/i2c_master_transaction_sequencer_tb.sv
